>>> rtl/psfi_pkg.sv
// Shared types, codes and constants for the position sensor fault injector.
// No dependencies; used by the top level, psfi_ctrl and psfi_dp.
package psfi_pkg;

	localparam int SENSOR_COUNT = 3;
	localparam int TRAVEL_LIMIT = 6553600;
	localparam int POS_W        = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int AMP_W        = 16;
	localparam int SEL_W        = 2;

	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_INC = 32'd1013904223;
	localparam int          PROD_W  = AMP_W + POS_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAULT_MODES = 3'd0,
		REG_STUCK_0     = 3'd1,
		REG_STUCK_1     = 3'd2,
		REG_STUCK_2     = 3'd3,
		REG_NOISE_EN    = 3'd4,
		REG_NOISE_SEED  = 3'd5,
		REG_NOISE_AMP   = 3'd6
	} reg_idx_t;

	typedef enum logic {
		CMD_SET  = 1'b0,
		CMD_READ = 1'b1
	} cmd_code_t;

	typedef enum logic [1:0] {
		MODE_NONE    = 2'd0,
		MODE_STUCK   = 2'd1,
		MODE_DELAYED = 2'd2,
		MODE_SILENT  = 2'd3
	} fault_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_STEP,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic lcg_mul;
		logic lcg_step;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_read;
		logic noisy;
		logic out_free;
	} dp_sts_t;

	localparam int NOISE_AMP_RESET = 6554;

	function automatic logic signed [POS_W-1:0] clamp_travel(input logic signed [POS_W:0] v);
		logic signed [POS_W:0] lim;
		lim = signed'((POS_W+1)'(TRAVEL_LIMIT));
		if (v > lim)
			return POS_W'(lim);
		else if (v < -lim)
			return POS_W'(-lim);
		else
			return POS_W'(v);
	endfunction

endpackage

>>> rtl/position_sensor_fault_injector_unit.sv
// Top level of the position sensor fault injector: controller plus datapath.
// Depends on psfi_pkg, psfi_ctrl and psfi_dp.
//
// Set beats (tuser bit 0 low) give no output; the next beat is taken in the
// following cycle. A read beat gives one reading (plain, stuck, delayed or silent
// sensor) through the ST_OUT state into the output register; with noise applied,
// ST_MUL and ST_STEP come first, as the 32-bit generator multiply and the amplitude
// multiply each take a state of their own. The input is held off while a read is in
// progress and while the output register still holds an untaken reading at its end.
module position_sensor_fault_injector_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [psfi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psfi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,  // [23:0] position
	input  logic [2:0]                          s_tuser,  // [0] command, [2:1] sensor_select
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata   // [23:0] reading
);

	psfi_pkg::dp_cmd_t cmd;
	psfi_pkg::dp_sts_t sts;

	psfi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psfi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> rtl/psfi_ctrl.sv
// Sequencing state machine for the fault injector.
// Depends on psfi_pkg; drives commands into psfi_dp and reads its status.
module psfi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  psfi_pkg::dp_sts_t sts,
	output psfi_pkg::dp_cmd_t cmd
);

	psfi_pkg::state_t state_q, state_nxt;
	logic             accept;

	assign accept = s_tvalid && (state_q == psfi_pkg::ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			psfi_pkg::ST_IDLE: begin
				if (accept && sts.is_read)
					state_nxt = sts.noisy ? psfi_pkg::ST_MUL : psfi_pkg::ST_OUT;
			end
			psfi_pkg::ST_MUL:  state_nxt = psfi_pkg::ST_STEP;
			psfi_pkg::ST_STEP: state_nxt = psfi_pkg::ST_OUT;
			psfi_pkg::ST_OUT: begin
				if (sts.out_free)
					state_nxt = psfi_pkg::ST_IDLE;
			end
			default: state_nxt = psfi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			psfi_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = accept;
			end
			psfi_pkg::ST_MUL:  cmd.lcg_mul  = 1'b1;
			psfi_pkg::ST_STEP: cmd.lcg_step = 1'b1;
			psfi_pkg::ST_OUT:  cmd.load_out = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= psfi_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

>>> rtl/psfi_dp.sv
// Datapath: configuration registers, targets, LCG noise pipeline, output register.
// Depends on psfi_pkg; sequenced by psfi_ctrl.
module psfi_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [psfi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [psfi_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic [2:0]                            s_tuser,
	input  logic [psfi_pkg::POS_W-1:0]            s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [psfi_pkg::POS_W-1:0]            m_tdata,
	input  psfi_pkg::dp_cmd_t                     cmd,
	output psfi_pkg::dp_sts_t                     sts
);

	localparam int PW = psfi_pkg::POS_W;
	localparam int AW = psfi_pkg::AMP_W;

	logic [5:0]                 fault_modes_q;
	logic signed [PW-1:0]       stuck_q [psfi_pkg::SENSOR_COUNT];
	logic                       noise_en_q;
	logic [AW-1:0]              noise_amp_q;
	logic [31:0]                noise_state_q;

	logic signed [PW-1:0]       cur_q;
	logic signed [PW-1:0]       prev_q;
	logic [psfi_pkg::SEL_W-1:0] sel_q;
	logic                       noisy_q;

	logic [31:0]                mul_s1;
	logic [psfi_pkg::PROD_W-1:0] prod_s2;

	logic [PW-1:0]              out_q;
	logic                       out_valid_q;

	logic [31:0]                lcg_next;
	logic [psfi_pkg::SEL_W-1:0] in_sel;
	psfi_pkg::fault_mode_t      in_mode;
	psfi_pkg::fault_mode_t      cur_mode;
	logic [psfi_pkg::PROD_W:0]  acc_sum;
	logic [AW:0]                acc;
	logic signed [AW+1:0]       noise;
	logic signed [PW:0]         noisy_sum;
	logic signed [PW-1:0]       plain_rd;
	logic signed [PW-1:0]       result;

	function automatic psfi_pkg::fault_mode_t mode_of(input logic [psfi_pkg::SEL_W-1:0] sel,
			input logic [5:0] modes);
		unique case (sel)
			2'd0:    return psfi_pkg::fault_mode_t'(modes[1:0]);
			2'd1:    return psfi_pkg::fault_mode_t'(modes[3:2]);
			2'd2:    return psfi_pkg::fault_mode_t'(modes[5:4]);
			default: return psfi_pkg::MODE_NONE;
		endcase
	endfunction

	assign in_sel   = s_tuser[2:1];
	assign in_mode  = mode_of(in_sel, fault_modes_q);
	assign cur_mode = mode_of(sel_q, fault_modes_q);
	assign lcg_next = mul_s1 + psfi_pkg::LCG_INC;

	assign sts.is_read  = (psfi_pkg::cmd_code_t'(s_tuser[0]) == psfi_pkg::CMD_READ);
	assign sts.noisy    = noise_en_q && (in_mode == psfi_pkg::MODE_NONE)
			&& (32'(in_sel) < 32'(psfi_pkg::SENSOR_COUNT));
	assign sts.out_free = !out_valid_q || m_tready;

	// noise = round(A * (u - 2^23) / 2^23), ties upward
	always_comb begin
		acc_sum   = {1'b0, prod_s2} + (psfi_pkg::PROD_W+1)'(1 << 22);
		acc       = acc_sum[psfi_pkg::PROD_W-1:23];
		noise     = signed'({1'b0, acc}) - signed'({2'b00, noise_amp_q});
		noisy_sum = (PW+1)'(cur_q) + (PW+1)'(noise);
	end

	always_comb begin
		plain_rd = '0;
		if (32'(sel_q) < 32'(psfi_pkg::SENSOR_COUNT)) begin
			unique case (cur_mode)
				psfi_pkg::MODE_STUCK:   plain_rd = stuck_q[sel_q];
				psfi_pkg::MODE_DELAYED: plain_rd = prev_q;
				psfi_pkg::MODE_SILENT:  plain_rd = '0;
				psfi_pkg::MODE_NONE:    plain_rd = cur_q;
				default:                plain_rd = '0;
			endcase
		end
		result = noisy_q ? psfi_pkg::clamp_travel(noisy_sum) : plain_rd;
	end

	// configuration and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_modes_q <= '0;
			for (int i = 0; i < psfi_pkg::SENSOR_COUNT; i++)
				stuck_q[i] <= '0;
			noise_en_q    <= 1'b0;
			noise_amp_q   <= AW'(psfi_pkg::NOISE_AMP_RESET);
			noise_state_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					psfi_pkg::REG_FAULT_MODES: fault_modes_q <= cfg_wdata[5:0];
					psfi_pkg::REG_STUCK_0:     stuck_q[0]    <= cfg_wdata[PW-1:0];
					psfi_pkg::REG_STUCK_1:     stuck_q[1]    <= cfg_wdata[PW-1:0];
					psfi_pkg::REG_STUCK_2:     stuck_q[2]    <= cfg_wdata[PW-1:0];
					psfi_pkg::REG_NOISE_EN:    noise_en_q    <= cfg_wdata[0];
					psfi_pkg::REG_NOISE_SEED:  noise_state_q <= cfg_wdata;
					psfi_pkg::REG_NOISE_AMP:   noise_amp_q   <= cfg_wdata[AW-1:0];
					default: ;
				endcase
			end
			if (cmd.lcg_step)
				noise_state_q <= lcg_next;
		end
	end

	// targets and captured request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			prev_q  <= '0;
			sel_q   <= '0;
			noisy_q <= 1'b0;
		end else if (cmd.capture) begin
			if (sts.is_read) begin
				sel_q   <= in_sel;
				noisy_q <= sts.noisy;
			end else begin
				prev_q <= cur_q;
				cur_q  <= psfi_pkg::clamp_travel(signed'({s_tdata[PW-1], s_tdata}));
			end
		end
	end

	// LCG multiply, then increment and amplitude scaling
	always_ff @(posedge clk) begin
		if (cmd.lcg_mul)
			mul_s1 <= noise_state_q * psfi_pkg::LCG_MUL;
		if (cmd.lcg_step)
			prod_s2 <= psfi_pkg::PROD_W'(noise_amp_q) * psfi_pkg::PROD_W'(lcg_next[31:8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

>>> rtl/psfi_checker.sv
// Port-level checks for the fault injector, bound onto the top level.
// Depends only on the top level's ports.
module psfi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// a set beat leaves the block ready for the next one
	a_set_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
		else $error("not ready after set beat");

	// a read beat keeps the input stalled while it is worked on
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
		else $error("input taken during a read");

	// no reading appears in the cycle right after a beat is taken
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("reading appeared too early");

endmodule

bind position_sensor_fault_injector_unit psfi_checker u_psfi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
